### rtl/humidity_sensor_frame_decoder_core_defines.svh
// Assertion macros shared by the frame decoder modules.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define HSFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define HSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hsfd_pkg.sv
// Shared types, constants and the CRC-8 step function of the frame decoder.
package hsfd_pkg;

	// CRC-8 with polynomial 0x31, MSB first, seeded with 0xFF.
	localparam logic [7:0] CrcInit = 8'hFF;
	localparam logic [7:0] CrcPoly = 8'h31;

	// Conversion scale factors and the temperature offset, in 0.01 units.
	localparam int unsigned TempScale  = 17500;
	localparam int unsigned HumScale   = 10000;
	localparam int unsigned TempOffset = 4500;

	// Default depth of the queue between the front and the back.
	localparam int unsigned FrameQueueDepth = 4;

	// Outcome of the two word checks of a frame.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_ERR = 2'd1,
		STATUS_HUM_ERR  = 2'd2
	} frame_status_t;

	// One completed frame as handed from the front to the back.
	typedef struct packed {
		logic [15:0]   temp_word;
		logic [15:0]   hum_word;
		frame_status_t status;
	} frame_rec_t;

	// Runs one byte through the CRC register, eight shifts MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] c;
		c = acc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/hsfd_front.sv
// Front part: takes frame bytes, runs the word checks and emits completed frames.
`include "humidity_sensor_frame_decoder_core_defines.svh"

module hsfd_front
	import hsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       rec_push,
	output frame_rec_t rec
);

	// Byte positions within one frame.
	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic        temp_ok_q;
	logic [15:0] held_temp_q;
	logic [15:0] held_hum_q;

	logic        restart;
	logic [2:0]  pos_eff;
	logic [7:0]  crc_cur;
	logic [7:0]  crc_next;

	// A frame start, or a position out of range, restarts the frame at the first byte.
	always_comb begin
		restart  = frame_start || (pos_q > POS_H_CRC);
		pos_eff  = restart ? POS_T_MSB : pos_q;
		crc_cur  = restart ? CrcInit : crc_q;
		crc_next = crc8_byte(crc_cur, rx_byte);
	end

	// The last byte of a frame completes a record for the back.
	always_comb begin
		rec_push      = accept && (pos_eff == POS_H_CRC);
		rec.temp_word = held_temp_q;
		rec.hum_word  = held_hum_q;
		priority if (!temp_ok_q) begin
			rec.status = STATUS_TEMP_ERR;
		end else if (crc_cur != rx_byte) begin
			rec.status = STATUS_HUM_ERR;
		end else begin
			rec.status = STATUS_OK;
		end
	end

	// Position and check state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_T_MSB;
			crc_q     <= CrcInit;
			temp_ok_q <= 1'b0;
		end else if (accept) begin
			unique case (pos_eff)
				POS_T_MSB, POS_T_LSB, POS_H_MSB, POS_H_LSB: begin
					crc_q <= crc_next;
					pos_q <= pos_eff + 3'd1;
				end
				POS_T_CRC: begin
					temp_ok_q <= (crc_cur == rx_byte);
					crc_q     <= CrcInit;
					pos_q     <= POS_H_MSB;
				end
				default: begin
					crc_q <= CrcInit;
					pos_q <= POS_T_MSB;
				end
			endcase
		end
	end

	// Word assembly.
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos_eff)
				POS_T_MSB: held_temp_q[15:8] <= rx_byte;
				POS_T_LSB: held_temp_q[7:0]  <= rx_byte;
				POS_H_MSB: held_hum_q[15:8]  <= rx_byte;
				POS_H_LSB: held_hum_q[7:0]   <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	`HSFD_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_H_CRC, "frame byte position out of range")

endmodule

### rtl/hsfd_queue.sv
// Short queue of completed frame records between the front and the back.
`include "humidity_sensor_frame_decoder_core_defines.svh"

module hsfd_queue
	import hsfd_pkg::*;
#(
	parameter int unsigned DEPTH = FrameQueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_rec_t wr_data,
	output logic       full,
	input  logic       pop,
	output frame_rec_t rd_data,
	output logic       empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

	frame_rec_t          entries_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push;
	logic                do_pop;

	// Status flags and the oldest entry.
	always_comb begin
		full    = (count_q == CntW'(DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rd_data = entries_q[rd_ptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	`HSFD_ASSERT_NOW(a_no_overflow, push, !full, "frame record pushed into a full queue")
	`HSFD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "queue count above depth")

endmodule

### rtl/hsfd_back.sv
// Back part: converts the raw words of a frame and holds the result for the reader.
`include "humidity_sensor_frame_decoder_core_defines.svh"

module hsfd_back
	import hsfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  frame_rec_t         in_rec,
	input  logic               in_empty,
	output logic               in_pop,
	output logic               out_empty,
	input  logic               out_pop,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        hum_centi,
	output logic [15:0]        temp_word,
	output logic [15:0]        hum_word,
	output logic [1:0]         frame_status
);

	localparam logic [30:0] TempScale31  = 31'(TempScale);
	localparam logic [30:0] HumScale31   = 31'(HumScale);
	localparam logic signed [15:0] TempOffset16 = 16'(TempOffset);

	// floor(p / 65535) for p below 2^31 and a quotient below 2^15:
	// p >> 16 is at most one short, and the remainder stays below twice 65535.
	function automatic logic [14:0] div65535(input logic [30:0] p);
		logic [14:0] q0;
		logic [16:0] rem;
		q0  = p[30:16];
		rem = {1'b0, p[15:0]} + {2'b00, q0};
		return (rem >= 17'd65535) ? q0 + 15'd1 : q0;
	endfunction

	logic               v_s1;
	frame_rec_t         rec_s1;
	logic [30:0]        temp_prod_s1;
	logic [30:0]        hum_prod_s1;

	logic               v_s2;
	logic signed [14:0] temp_centi_s2;
	logic [13:0]        hum_centi_s2;
	logic [15:0]        temp_word_s2;
	logic [15:0]        hum_word_s2;
	frame_status_t      status_s2;

	logic               adv_s2;
	logic               adv_s1;
	logic [14:0]        temp_quo;
	logic [14:0]        hum_quo;
	logic signed [15:0] temp_diff;

	// Stage advance: each stage moves when the one after it is free or being drained.
	always_comb begin
		adv_s2 = !v_s2 || out_pop;
		adv_s1 = !v_s1 || adv_s2;
		in_pop = adv_s1 && !in_empty;
	end

	// Division by 65535 and offset of the temperature.
	always_comb begin
		temp_quo  = div65535(temp_prod_s1);
		hum_quo   = div65535(hum_prod_s1);
		temp_diff = $signed({1'b0, temp_quo}) - TempOffset16;
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= !in_empty;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: scale the raw words.
	always_ff @(posedge clk) begin
		if (in_pop) begin
			rec_s1       <= in_rec;
			temp_prod_s1 <= {15'd0, in_rec.temp_word} * TempScale31;
			hum_prod_s1  <= {15'd0, in_rec.hum_word} * HumScale31;
		end
	end

	// Stage 2: finished result, zeroed on a check error.
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			temp_word_s2 <= rec_s1.temp_word;
			hum_word_s2  <= rec_s1.hum_word;
			status_s2    <= rec_s1.status;
			if (rec_s1.status == STATUS_OK) begin
				temp_centi_s2 <= temp_diff[14:0];
				hum_centi_s2  <= hum_quo[13:0];
			end else begin
				temp_centi_s2 <= '0;
				hum_centi_s2  <= '0;
			end
		end
	end

	assign out_empty    = !v_s2;
	assign temp_centi   = temp_centi_s2;
	assign hum_centi    = hum_centi_s2;
	assign temp_word    = temp_word_s2;
	assign hum_word     = hum_word_s2;
	assign frame_status = status_s2;

	`HSFD_ASSERT_NOW(a_err_zero, v_s2 && (status_s2 != STATUS_OK),
		(temp_centi_s2 == '0) && (hum_centi_s2 == '0), "converted fields not zero on error")
	`HSFD_ASSERT_NEXT(a_s1_held, v_s1 && !adv_s2, v_s1, "stage 1 frame lost during stall")

endmodule

### rtl/humidity_sensor_frame_decoder_core.sv
// Top level of the sensor frame decoder: front, frame queue and back.
//
//   channel   direction  handshake       payload
//   bytes     in         push / full     rx_byte, frame_start
//   results   out        empty / pop     temp_centi, hum_centi, temp_word, hum_word,
//                                        frame_status
//
// One byte request is taken per cycle while full is low; a frame of six bytes yields one result.
// After its last byte is taken, a result is written into the frame queue, then registered by the
// queue read and the scaling multiply, then by the division by 65535 onto the outputs.
// full rises only while the frame queue holds FRAME_QUEUE_DEPTH records.
// Reset clears the byte position, the check register and all valid state; no sweep.
module humidity_sensor_frame_decoder_core
	import hsfd_pkg::*;
#(
	parameter int unsigned FRAME_QUEUE_DEPTH = FrameQueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               empty,
	input  logic               pop,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        hum_centi,
	output logic [15:0]        temp_word,
	output logic [15:0]        hum_word,
	output logic [1:0]         frame_status
);

	logic       accept;
	logic       rec_push;
	frame_rec_t rec_in;
	frame_rec_t rec_out;
	logic       rec_empty;
	logic       rec_pop;
	logic       rec_full;

	// A byte request is taken whenever the queue has room for a finished frame.
	assign full   = rec_full;
	assign accept = push && !rec_full;

	hsfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	hsfd_queue #(
		.DEPTH (FRAME_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.wr_data (rec_in),
		.full    (rec_full),
		.pop     (rec_pop),
		.rd_data (rec_out),
		.empty   (rec_empty)
	);

	hsfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_rec       (rec_out),
		.in_empty     (rec_empty),
		.in_pop       (rec_pop),
		.out_empty    (empty),
		.out_pop      (pop),
		.temp_centi   (temp_centi),
		.hum_centi    (hum_centi),
		.temp_word    (temp_word),
		.hum_word     (hum_word),
		.frame_status (frame_status)
	);

endmodule
